// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the text layout RTL.
// Simulation builds get the checks; synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(name, clk, rst, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(name, clk, rst, expr, msg)
`define ASSERT_IMPL(name, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg)
`endif
`endif

// ----- rtl/core/utl_pkg.sv -----
// Types, constants and the glyph placement function for the text layout core.
// No dependencies.
`default_nettype none
package utl_pkg;

  localparam logic [20:0] REPLACEMENT = 21'h00FFFD;
  localparam logic [20:0] CP_NEWLINE  = 21'h00000A;
  localparam logic [20:0] CP_ASCII_END = 21'h000080;
  localparam logic [15:0] LINE_MAX    = 16'hFFFF;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LINES  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_STEP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_LINES = 3'd5;

  localparam logic [9:0]  RST_MAX_WIDTH = 10'd240;
  localparam logic [7:0]  RST_MAX_LINES = 8'd1;
  localparam logic [5:0]  RST_LINE_STEP = 6'd12;

  typedef struct packed {
    logic [9:0]  origin_x;
    logic [9:0]  origin_y;
    logic [9:0]  max_width;
    logic [7:0]  max_lines;
    logic [5:0]  line_step;
    logic [15:0] skip_lines;
  } cfg_t;

  typedef struct packed {
    logic        glyph_valid;
    logic [20:0] code_point;
    logic        is_wide;
    logic        visible;
    logic [10:0] pixel_x;
    logic [14:0] pixel_y;
    logic        last;
    logic [15:0] total_lines;
  } result_t;

  typedef struct packed {
    logic        emit;
    result_t     res;
    logic [10:0] cursor;
    logic [15:0] line;
  } place_t;

  function automatic logic [15:0] line_inc(input logic [15:0] line);
    return (line == LINE_MAX) ? line : line + 16'd1;
  endfunction

  // One code point onto the wrapped grid. Newline emits nothing; it resets the cursor and advances the line.
  function automatic place_t place_cp(input logic [20:0] cp, input logic [10:0] cursor,
                                      input logic [15:0] line, input cfg_t cfg,
                                      input logic [5:0] narrow_w, input logic [5:0] wide_w);
    logic        narrow;
    logic [5:0]  w;
    logic [11:0] span;
    logic [10:0] cur;
    logic [15:0] ln;
    logic [15:0] rel;
    logic        shown;
    logic [13:0] prod;
    place_t      p;
    p      = '0;
    narrow = cp < CP_ASCII_END;
    w      = narrow ? narrow_w : wide_w;
    if (cp == CP_NEWLINE) begin
      p.cursor = '0;
      p.line   = line_inc(line);
    end else begin
      span = {1'b0, cursor} + {6'b0, w};
      if (span > {2'b0, cfg.max_width}) begin
        cur = '0;
        ln  = line_inc(line);
      end else begin
        cur = cursor;
        ln  = line;
      end
      rel   = ln - cfg.skip_lines;
      shown = (ln >= cfg.skip_lines) && (rel < {8'b0, cfg.max_lines});
      prod  = rel[7:0] * cfg.line_step;
      p.emit             = 1'b1;
      p.res.glyph_valid  = 1'b1;
      p.res.code_point   = cp;
      p.res.is_wide      = !narrow;
      p.res.visible      = shown;
      p.res.pixel_x      = {1'b0, cfg.origin_x} + cur;
      p.res.pixel_y      = shown ? ({5'b0, cfg.origin_y} + {1'b0, prod}) : 15'd0;
      p.cursor           = cur + {5'b0, w};
      p.line             = ln;
    end
    return p;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/utl_out_fifo.sv -----
// Three-entry result queue; takes up to two items per cycle while room is set.
// Depends on utl_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module utl_out_fifo (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [1:0]       push_n,
  input  utl_pkg::result_t      push_data0,
  input  utl_pkg::result_t      push_data1,
  output logic                  room,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output utl_pkg::result_t      out_data
);
  import utl_pkg::*;

  result_t    mem [3];
  logic [1:0] wp;
  logic [1:0] rp;
  logic [1:0] count;
  logic [1:0] wp1;
  logic [1:0] wp2;
  logic       pop;

  function automatic logic [1:0] inc3(input logic [1:0] v);
    return (v == 2'd2) ? 2'd0 : v + 2'd1;
  endfunction

  assign wp1       = inc3(wp);
  assign wp2       = inc3(wp1);
  assign room      = count <= 2'd1;
  assign out_valid = count != 2'd0;
  assign out_data  = mem[rp];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      case (push_n)
        2'd1:    wp <= wp1;
        2'd2:    wp <= wp2;
        default: wp <= wp;
      endcase
      if (pop) begin
        rp <= inc3(rp);
      end
      count <= count + push_n - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wp] <= push_data0;
    end
    if (push_n == 2'd2) begin
      mem[wp1] <= push_data1;
    end
  end

  `ASSERT_IMPL(a_no_overfill, clk, rst, push_n != 2'd0, count <= 2'd1, "push into full queue")
  `ASSERT_ALWAYS(a_push_n_max, clk, rst, push_n != 2'd3, "more than two items pushed")
  `ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && !out_ready && push_n == 2'd0, count == $past(count), "queue level moved while stalled")

endmodule
`default_nettype wire

// ----- rtl/core/utf8_text_wrap_layout_core.sv -----
// UTF-8 decoder with fixed-pitch line wrap. One input byte per item.
// Each result goes into the registered result queue when its byte is accepted.
// Throughput: one byte per cycle while the result queue has room; a byte that yields two items
// can drop s_tready while the three-entry result queue drains.
// Reset: config returns to its defaults, decoder, cursor and line state clear,
// result queue empties.
// Depends on utl_pkg, utl_out_fifo, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module utf8_text_wrap_layout_core #(
  parameter int NARROW_WIDTH = 6,
  parameter int WIDE_WIDTH   = 12
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [7:0]                    s_tdata,   // [7:0] text_byte
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // [20:0] code_point, [21] is_wide, [22] visible, [33:23] pixel_x,
  // [48:34] pixel_y, [64:49] total_lines, [71:65] zero
  output logic [71:0]                        m_tdata,
  output logic                               m_tuser,   // [0] glyph_valid
  output logic                               m_tlast,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [utl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                   cfg_data
);
  import utl_pkg::*;

  localparam logic [5:0] NW = 6'(NARROW_WIDTH);
  localparam logic [5:0] WW = 6'(WIDE_WIDTH);

  cfg_t        cfg;
  logic [1:0]  bytes_pending;
  logic [20:0] partial_code;
  logic [10:0] cursor_offset;
  logic [15:0] line_index;

  logic [1:0]  bytes_pending_next;
  logic [20:0] partial_code_next;
  logic [10:0] cursor_offset_next;
  logic [15:0] line_index_next;

  logic        s_accept;
  logic        pend;
  logic        cont;
  logic [20:0] partial_shift;
  place_t      pa;
  place_t      pr;
  place_t      pb;
  place_t      pf;
  logic [10:0] cur1;
  logic [15:0] line1;
  logic        a_v;
  logic        b_v;
  result_t     a_res;
  result_t     b_res;
  result_t     sum_res;
  result_t     d0;
  result_t     d1;
  logic [1:0]  push_n;
  logic        room;
  result_t     out_res;

  assign cfg_ready = 1'b1;
  assign s_tready  = room;
  assign s_accept  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x   <= '0;
      cfg.origin_y   <= '0;
      cfg.max_width  <= RST_MAX_WIDTH;
      cfg.max_lines  <= RST_MAX_LINES;
      cfg.line_step  <= RST_LINE_STEP;
      cfg.skip_lines <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ORIGIN_X:   cfg.origin_x   <= cfg_data[9:0];
        CFG_ORIGIN_Y:   cfg.origin_y   <= cfg_data[9:0];
        CFG_MAX_WIDTH:  cfg.max_width  <= cfg_data[9:0];
        CFG_MAX_LINES:  cfg.max_lines  <= cfg_data[7:0];
        CFG_LINE_STEP:  cfg.line_step  <= cfg_data[5:0];
        CFG_SKIP_LINES: cfg.skip_lines <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pend          = bytes_pending != 2'd0;
  assign cont          = s_tdata[7:6] == 2'b10;
  assign partial_shift = {partial_code[14:0], s_tdata[5:0]};

  // first placement: finished sequence or replacement for a broken one
  assign pa    = place_cp(partial_shift, cursor_offset, line_index, cfg, NW, WW);
  assign pr    = place_cp(REPLACEMENT, cursor_offset, line_index, cfg, NW, WW);
  assign cur1  = pend ? pr.cursor : cursor_offset;
  assign line1 = pend ? pr.line : line_index;
  // second placement: the byte taken as a lead
  assign pb    = place_cp({13'b0, s_tdata}, cur1, line1, cfg, NW, WW);
  assign pf    = place_cp(REPLACEMENT, cur1, line1, cfg, NW, WW);

  always_comb begin
    sum_res             = '0;
    sum_res.last        = 1'b1;
    sum_res.total_lines = (line1 == LINE_MAX) ? LINE_MAX : line1 + 16'd1;
  end

  always_comb begin
    bytes_pending_next = bytes_pending;
    partial_code_next  = partial_code;
    cursor_offset_next = cursor_offset;
    line_index_next    = line_index;
    a_v   = 1'b0;
    a_res = pr.res;
    b_v   = 1'b0;
    b_res = pb.res;
    if (pend && cont) begin
      partial_code_next  = partial_shift;
      bytes_pending_next = bytes_pending - 2'd1;
      if (bytes_pending == 2'd1) begin
        partial_code_next  = '0;
        a_v                = pa.emit;
        a_res              = pa.res;
        cursor_offset_next = pa.cursor;
        line_index_next    = pa.line;
      end
    end else begin
      a_v                = pend;
      bytes_pending_next = '0;
      partial_code_next  = '0;
      cursor_offset_next = cur1;
      line_index_next    = line1;
      if (s_tdata == 8'd0) begin
        b_v                = 1'b1;
        b_res              = sum_res;
        cursor_offset_next = '0;
        line_index_next    = '0;
      end else if (!s_tdata[7]) begin
        b_v                = pb.emit;
        cursor_offset_next = pb.cursor;
        line_index_next    = pb.line;
      end else if (s_tdata[7:5] == 3'b110) begin
        partial_code_next  = {16'b0, s_tdata[4:0]};
        bytes_pending_next = 2'd1;
      end else if (s_tdata[7:4] == 4'b1110) begin
        partial_code_next  = {17'b0, s_tdata[3:0]};
        bytes_pending_next = 2'd2;
      end else if (s_tdata[7:3] == 5'b11110) begin
        partial_code_next  = {18'b0, s_tdata[2:0]};
        bytes_pending_next = 2'd3;
      end else begin
        b_v                = 1'b1;
        b_res              = pf.res;
        cursor_offset_next = pf.cursor;
        line_index_next    = pf.line;
      end
    end
  end

  always_comb begin
    d0 = a_v ? a_res : b_res;
    d1 = b_res;
    if (!s_accept) begin
      push_n = 2'd0;
    end else begin
      push_n = {1'b0, a_v} + {1'b0, b_v};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= '0;
      partial_code  <= '0;
      cursor_offset <= '0;
      line_index    <= '0;
    end else if (s_accept) begin
      bytes_pending <= bytes_pending_next;
      partial_code  <= partial_code_next;
      cursor_offset <= cursor_offset_next;
      line_index    <= line_index_next;
    end
  end

  utl_out_fifo u_out_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_n     (push_n),
    .push_data0 (d0),
    .push_data1 (d1),
    .room       (room),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (out_res)
  );

  assign m_tdata = {7'b0, out_res.total_lines, out_res.pixel_y, out_res.pixel_x,
                    out_res.visible, out_res.is_wide, out_res.code_point};
  assign m_tuser = out_res.glyph_valid;
  assign m_tlast = out_res.last;

  `ASSERT_ALWAYS(a_partial_idle, clk, rst, bytes_pending != 2'd0 || partial_code == 21'd0, "partial code left without pending bytes")
  `ASSERT_NEXT(a_nul_clears, clk, rst, s_accept && s_tdata == 8'd0, line_index == 16'd0 && cursor_offset == 11'd0 && bytes_pending == 2'd0, "string state not cleared after NUL")
  `ASSERT_NEXT(a_nul_summary, clk, rst, s_accept && s_tdata == 8'd0 && !m_tvalid, m_tvalid && (m_tlast || m_tuser), "NUL gave no item")

endmodule
`default_nettype wire
